// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCP_ASSERT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> cons) \
    else $error("assertion failed");

// next-cycle implication
`define RCP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> cons) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcp_pkg
// Constants, widths and the arctangent table of the raised-cosine pulse block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

  localparam int CORDIC_STAGES  = 18;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 2;

  localparam int CORDIC_N   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CORDIC_LAT = CORDIC_N + 2;
  localparam int XW         = 34;
  localparam int ZW         = 34;

  localparam int DIV_QW  = 33;
  localparam int DIV_NW  = 62;
  localparam int DIV_DW  = 54;
  localparam int DIV_LAT = DIV_QW + 2;

  // accept to result strobe
  localparam int PIPE_LAT = 4 + CORDIC_LAT + DIV_LAT + 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLLOFF     = 2'd2;

  localparam logic [31:0]        PI_Q30   = 32'd3373259426;
  localparam logic [29:0]        PI_Q28   = 30'd843314857;
  localparam logic signed [32:0] PI4_Q30  = 33'sd843314857;
  localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

  typedef struct packed {
    logic        tz;
    logic        sing;
    logic [43:0] den;
  } side_t;

  typedef struct packed {
    logic tz;
    logic sing;
  } flag_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] k);
    logic [29:0] a;
    case (k)
      5'd0:  a = 30'h3243F6A8;
      5'd1:  a = 30'h1DAC6705;
      5'd2:  a = 30'h0FADBAFC;
      5'd3:  a = 30'h07F56EA6;
      5'd4:  a = 30'h03FEAB76;
      5'd5:  a = 30'h01FFD55B;
      5'd6:  a = 30'h00FFFAAA;
      5'd7:  a = 30'h007FFF55;
      5'd8:  a = 30'h003FFFEA;
      5'd9:  a = 30'h001FFFFD;
      5'd10: a = 30'h000FFFFF;
      5'd11: a = 30'h0007FFFF;
      5'd12: a = 30'h0003FFFF;
      5'd13: a = 30'h0001FFFF;
      5'd14: a = 30'h0000FFFF;
      5'd15: a = 30'h00007FFF;
      5'd16: a = 30'h00003FFF;
      5'd17: a = 30'h00001FFF;
      5'd18: a = 30'h00000FFF;
      5'd19: a = 30'h000007FF;
      5'd20: a = 30'h000003FF;
      5'd21: a = 30'h000001FF;
      5'd22: a = 30'h000000FF;
      5'd23: a = 30'h0000007F;
      5'd24: a = 30'h0000003F;
      5'd25: a = 30'h0000001F;
      5'd26: a = 30'h0000000F;
      5'd27: a = 30'h00000008;
      5'd28: a = 30'h00000004;
      5'd29: a = 30'h00000002;
      5'd30: a = 30'h00000001;
      default: a = 30'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcp_cordic.sv =====
// ----------------------------------------------------------------------------
// rcp_cordic
// Pipelined rotation CORDIC: sin and cos of pi*x, one stage per iteration,
// quadrant folded back at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_cordic (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic [30:0]                      in_angle,
  input  wire logic [1:0]                       in_quad,
  output logic                                  out_valid,
  output logic signed [rcp_pkg::XW-1:0]         sin_val,
  output logic signed [rcp_pkg::XW-1:0]         cos_val
);

  localparam int N  = rcp_pkg::CORDIC_N;
  localparam int XW = rcp_pkg::XW;
  localparam int ZW = rcp_pkg::ZW;

  logic signed [XW-1:0] xs [0:N];
  logic signed [XW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic [1:0]           qs [0:N];
  logic                 vs [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    xs[0] <= rcp_pkg::GAIN_Q30;
    ys[0] <= '0;
    zs[0] <= ZW'(in_angle);
    qs[0] <= in_quad;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = ZW'(rcp_pkg::atan_q30(5'(i)));
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      qs[i+1] <= qs[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ATAN;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vs[N];
    end
    case (qs[N])
      2'd0: begin
        sin_val <= ys[N];
        cos_val <= xs[N];
      end
      2'd1: begin
        sin_val <= xs[N];
        cos_val <= -ys[N];
      end
      2'd2: begin
        sin_val <= -ys[N];
        cos_val <= -xs[N];
      end
      default: begin
        sin_val <= -xs[N];
        cos_val <= ys[N];
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rcp_div.sv =====
// ----------------------------------------------------------------------------
// rcp_div
// Pipelined restoring divider, one quotient bit per stage. Truncates toward
// zero and saturates the magnitude at 2.0 in Q.30.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic [rcp_pkg::DIV_NW-1:0]        num_mag,
  input  wire logic [rcp_pkg::DIV_DW-1:0]        den_mag,
  input  wire logic                              neg,
  output logic                                   out_valid,
  output logic signed [rcp_pkg::DIV_QW-1:0]      quot
);

  localparam int QW = rcp_pkg::DIV_QW;
  localparam int NW = rcp_pkg::DIV_NW;
  localparam int DW = rcp_pkg::DIV_DW;
  localparam logic [QW-1:0] LIM = QW'(1) << 31;

  logic          v_s   [0:QW];
  logic          ovf_s [0:QW];
  logic          neg_s [0:QW];
  logic [DW-1:0] den_s [0:QW];
  logic [DW-1:0] rem_s [0:QW];
  logic [QW-1:0] lo_s  [0:QW];
  logic [QW-1:0] q_s   [0:QW];
  logic [QW-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= in_valid;
    end
    // quotient would not fit: saturate later
    ovf_s[0] <= (num_mag >> QW) >= NW'(den_mag);
    neg_s[0] <= neg;
    den_s[0] <= den_mag;
    rem_s[0] <= DW'(num_mag >> QW);
    lo_s[0]  <= num_mag[QW-1:0];
    q_s[0]   <= '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW:0] trial;
    assign trial = {rem_s[j], lo_s[j][QW-1-j]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else begin
        v_s[j+1] <= v_s[j];
      end
      ovf_s[j+1] <= ovf_s[j];
      neg_s[j+1] <= neg_s[j];
      den_s[j+1] <= den_s[j];
      lo_s[j+1]  <= lo_s[j];
      if (trial >= {1'b0, den_s[j]}) begin
        rem_s[j+1] <= DW'(trial - {1'b0, den_s[j]});
        q_s[j+1]   <= {q_s[j][QW-2:0], 1'b1};
      end else begin
        rem_s[j+1] <= trial[DW-1:0];
        q_s[j+1]   <= {q_s[j][QW-2:0], 1'b0};
      end
    end
  end

  assign mag = (ovf_s[QW] || (q_s[QW] > LIM)) ? LIM : q_s[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_s[QW];
    end
    quot <= neg_s[QW] ? -$signed(mag) : $signed(mag);
  end

endmodule

`default_nettype wire

// ===== rtl/core/raised_cosine_pulse_sample.sv =====
// ----------------------------------------------------------------------------
// raised_cosine_pulse_sample
// Raised-cosine filter coefficient at a sample position, fully pipelined.
// ----------------------------------------------------------------------------
// One position is taken per clock while busy is low; its coefficient appears
// on coefficient with done high for one cycle, after the input stages, the
// CORDIC pipelines, the dividers and the select, product and rounding
// registers. The two CORDIC pipelines (one stage per iteration) run in
// parallel, as do the two 33-stage restoring dividers. There is no output
// hold: the receiver must take every result. busy is high only during reset.
// Configuration may be written only while no request is in flight.
`default_nettype none

module raised_cosine_pulse_sample (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [15:0]                        position,
  input  wire logic                               cfg_write,
  input  wire logic [rcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                    done,
  output logic signed [rcp_pkg::COEF_W-1:0]       coefficient
);

  localparam int N        = rcp_pkg::CORDIC_N;
  localparam int CLAT     = rcp_pkg::CORDIC_LAT;
  localparam int DLAT     = rcp_pkg::DIV_LAT;
  localparam int XW       = rcp_pkg::XW;
  localparam int ROUND_SH = 60 - rcp_pkg::COEF_FRAC_BITS;
  localparam logic signed [65:0] ONE_W = 66'sd1 <<< rcp_pkg::COEF_FRAC_BITS;
  localparam logic signed [65:0] HALF  = 66'sd1 <<< (ROUND_SH - 1);

  // configuration
  logic [11:0] tap_count;
  logic [15:0] symbol_rate;
  logic [16:0] rolloff;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= 12'd64;
      symbol_rate <= 16'd4096;
      rolloff     <= 17'd65536;
    end else if (cfg_write) begin
      case (cfg_index)
        rcp_pkg::REG_TAP_COUNT:   tap_count   <= cfg_data[11:0];
        rcp_pkg::REG_SYMBOL_RATE: symbol_rate <= cfg_data[15:0];
        rcp_pkg::REG_ROLLOFF:     rolloff     <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // stage 1: distance from pulse center
  logic [15:0] ctr;
  logic        v1;
  logic [15:0] diff1;

  assign ctr = 16'({tap_count, 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    diff1 <= (position > ctr) ? (position - ctr) : (ctr - position);
  end

  // stage 2: tau, Q.20
  logic        v2;
  logic [31:0] tau2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    tau2 <= 32'(diff1) * 32'(symbol_rate);
  end

  // stage 3: u, sinc denominator, angle of tau
  logic [48:0] mul_u;
  logic [61:0] mul_den;
  logic [50:0] mul_zt;
  logic        v3;
  logic [32:0] u3;
  logic [43:0] den3;
  logic [30:0] zt3;
  logic [1:0]  qt3;
  logic        tz3;

  assign mul_u   = 49'(tau2) * 49'(rolloff);
  assign mul_den = 62'(tau2) * 62'(rcp_pkg::PI_Q28);
  assign mul_zt  = 51'(tau2[18:0]) * 51'(rcp_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    u3   <= mul_u[48:16];
    den3 <= mul_den[61:18];
    zt3  <= mul_zt[50:20];
    qt3  <= tau2[20:19];
    tz3  <= (tau2 == 32'd0);
  end

  // stage 4: angle of u, saturated u, singular point
  logic [50:0]        mul_zu;
  logic               v4;
  logic [30:0]        zt4;
  logic [1:0]         qt4;
  logic [30:0]        zu4;
  logic [1:0]         qu4;
  logic [30:0]        uc4;
  rcp_pkg::side_t     side4;

  assign mul_zu = 51'(u3[18:0]) * 51'(rcp_pkg::PI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    zt4        <= zt3;
    qt4        <= qt3;
    zu4        <= mul_zu[50:20];
    qu4        <= u3[20:19];
    uc4        <= (u3 > (33'd1 << 30)) ? (31'd1 << 30) : u3[30:0];
    side4.tz   <= tz3;
    side4.sing <= (u3 >= 33'd524272) && (u3 <= 33'd524304);
    side4.den  <= den3;
  end

  // stage 5/6: roll-off denominator, Q.30
  logic [61:0]        sq5;
  logic signed [63:0] d40;
  logic signed [53:0] d30_dly [0:N];

  assign d40 = (64'sd1 <<< 40) - $signed({sq5, 2'b00});

  always_ff @(posedge clk) begin
    sq5        <= 62'(uc4) * 62'(uc4);
    d30_dly[0] <= d40[63:10];
    for (int k = 1; k <= N; k++) begin
      d30_dly[k] <= d30_dly[k-1];
    end
  end

  // sideband alongside the CORDICs
  rcp_pkg::side_t side_dly [0:CLAT-1];

  always_ff @(posedge clk) begin
    side_dly[0] <= side4;
    for (int k = 1; k < CLAT; k++) begin
      side_dly[k] <= side_dly[k-1];
    end
  end

  logic                 cv;
  logic signed [XW-1:0] sin_t;
  logic signed [XW-1:0] cos_t;
  logic signed [XW-1:0] cos_u;

  rcp_cordic u_cordic_tau (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_angle  (zt4),
    .in_quad   (qt4),
    .out_valid (cv),
    .sin_val   (sin_t),
    .cos_val   ()
  );

  rcp_cordic u_cordic_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_angle  (zu4),
    .in_quad   (qu4),
    .out_valid (),
    .sin_val   (),
    .cos_val   (cos_u)
  );

  // divider operands
  logic [XW-1:0]                   abs_s;
  logic [XW-1:0]                   abs_c;
  logic signed [53:0]              d30c;
  logic [53:0]                     abs_d;
  logic                            dv;
  logic signed [rcp_pkg::DIV_QW-1:0] sinc_q;
  logic signed [rcp_pkg::DIV_QW-1:0] fac_q;

  assign d30c  = d30_dly[N];
  assign abs_s = sin_t[XW-1] ? XW'(-sin_t) : XW'(sin_t);
  assign abs_c = cos_u[XW-1] ? XW'(-cos_u) : XW'(cos_u);
  assign abs_d = d30c[53] ? 54'(-d30c) : 54'(d30c);

  rcp_div u_div_sinc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv),
    .num_mag   ({abs_s[31:0], 30'd0}),
    .den_mag   (54'(side_dly[CLAT-1].den)),
    .neg       (sin_t[XW-1]),
    .out_valid (dv),
    .quot      (sinc_q)
  );

  rcp_div u_div_fac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv),
    .num_mag   ({abs_c[31:0], 30'd0}),
    .den_mag   (abs_d),
    .neg       (cos_u[XW-1] ^ d30c[53]),
    .out_valid (),
    .quot      (fac_q)
  );

  rcp_pkg::flag_t flag_dly [0:DLAT-1];

  always_ff @(posedge clk) begin
    flag_dly[0].tz   <= side_dly[CLAT-1].tz;
    flag_dly[0].sing <= side_dly[CLAT-1].sing;
    for (int k = 1; k < DLAT; k++) begin
      flag_dly[k] <= flag_dly[k-1];
    end
  end

  // factor select
  logic               vf;
  logic               tzf;
  logic signed [32:0] sinc_f;
  logic signed [32:0] fac_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= dv;
    end
    tzf    <= flag_dly[DLAT-1].tz;
    sinc_f <= sinc_q;
    fac_f  <= flag_dly[DLAT-1].sing ? rcp_pkg::PI4_Q30 : fac_q;
  end

  // product, Q.60
  logic               vp;
  logic               tzp;
  logic signed [65:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else begin
      vp <= vf;
    end
    tzp  <= tzf;
    prod <= 66'(fac_f) * 66'(sinc_f);
  end

  // round half up, clamp to plus or minus one
  logic signed [65:0] rsum;
  logic signed [65:0] rsh;
  logic signed [65:0] rclamp;

  assign rsum   = prod + HALF;
  assign rsh    = rsum >>> ROUND_SH;
  assign rclamp = (rsh > ONE_W) ? ONE_W : ((rsh < -ONE_W) ? -ONE_W : rsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vp;
    end
    coefficient <= tzp ? rcp_pkg::COEF_W'(ONE_W) : rcp_pkg::COEF_W'(rclamp);
  end

endmodule

`default_nettype wire

// ===== rtl/core/rcp_checker.sv =====
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks of the raised-cosine pulse block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcp_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done,
  input wire logic signed [rcp_pkg::COEF_W-1:0]  coefficient
);

  localparam int LAT = rcp_pkg::PIPE_LAT;
  localparam logic signed [rcp_pkg::COEF_W-1:0] ONE =
    rcp_pkg::COEF_W'(1) << rcp_pkg::COEF_FRAC_BITS;

  // every request yields exactly one result at fixed latency
  `RCP_ASSERT(a_req_done, clk, rst, start && !busy, ##LAT done)
  `RCP_ASSERT(a_done_req, clk, rst, done, $past(start && !busy, LAT))
  `RCP_ASSERT(a_range, clk, rst, done, (coefficient <= ONE && coefficient >= -ONE))
  // pipeline flushed by reset
  `RCP_ASSERT_NEXT(a_rst_flush, clk, 1'b0, rst, !done)

endmodule

bind raised_cosine_pulse_sample rcp_checker u_rcp_checker (.*);

`default_nettype wire
